FILE: rtl/icmpchk_pkg.sv
`timescale 1ns / 1ps

package icmpchk_pkg;

  localparam logic [15:0] MaxPacketBytes = 16'd1280;
  localparam logic [15:0] V4Hdr          = 16'd20;
  localparam logic [15:0] V6Hdr          = 16'd40;
  localparam logic [16:0] V4Strip        = 17'd28;  // IPv4 header + ICMP header
  localparam logic [16:0] V6Strip        = 17'd48;  // IPv6 header + ICMP header
  localparam logic [16:0] V6HdrWide      = 17'd40;
  localparam logic [7:0]  ProtoIcmp      = 8'd1;
  localparam logic [7:0]  NextIcmpv6     = 8'd58;
  localparam logic [15:0] SumGood        = 16'hFFFF;

  typedef enum logic {
    CfgIpv6Mode = 1'b0,
    CfgExpSeq   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StNotIcmp  = 3'd2,
    StChecksum = 3'd3,
    StSequence = 3'd4,
    StLength   = 3'd5
  } status_e;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        v6;
    logic [7:0]  exp_seq;
    logic        hi_store;   // even byte of a summed word
    logic        add_word;   // odd byte closes a word
    logic        add_low;    // IPv6 next header added as low byte
    logic        pad;        // odd length: pad last high byte
    logic        len_hi;
    logic        len_lo;
    logic        proto_chk;
    logic        proto_ok;
    logic        seq_cap;
    logic [15:0] len;        // byte count including this byte
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/icmpchk_front.sv
`timescale 1ns / 1ps

module icmpchk_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  icmpchk_pkg::q_stat_t  q_stat_i,
  output logic                  push_o,
  output icmpchk_pkg::entry_t   entry_o
);

  logic        v6_q;
  logic [7:0]  exp_seq_q;
  logic [15:0] count_q, count_d;
  logic [15:0] idx, len, len_m1, hdr;
  logic        counted;
  logic        region_idx, region_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q      <= 1'b0;
      exp_seq_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        icmpchk_pkg::CfgIpv6Mode: v6_q      <= cfg_data_i[0];
        icmpchk_pkg::CfgExpSeq:   exp_seq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  assign idx     = count_q;
  assign counted = count_q < icmpchk_pkg::MaxPacketBytes;
  assign len     = counted ? count_q + 16'd1 : count_q;
  assign len_m1  = len - 16'd1;
  assign hdr     = v6_q ? icmpchk_pkg::V6Hdr : icmpchk_pkg::V4Hdr;

  always_comb begin
    if (v6_q) begin
      region_idx = (idx == 16'd4) || (idx == 16'd5) || (idx >= 16'd8);
      region_end = (len_m1 == 16'd4) || (len_m1 == 16'd5) || (len_m1 >= 16'd8);
    end else begin
      region_idx = idx >= icmpchk_pkg::V4Hdr;
      region_end = len_m1 >= icmpchk_pkg::V4Hdr;
    end
  end

  always_comb begin
    entry_o.data      = data_byte_i;
    entry_o.last      = last_byte_i;
    entry_o.v6        = v6_q;
    entry_o.exp_seq   = exp_seq_q;
    entry_o.hi_store  = counted && region_idx && !idx[0];
    entry_o.add_word  = counted && region_idx && idx[0];
    entry_o.add_low   = counted && v6_q && (idx == 16'd6);
    entry_o.pad       = last_byte_i && len[0] && region_end;
    entry_o.len_hi    = counted && (idx == (v6_q ? 16'd4 : 16'd2));
    entry_o.len_lo    = counted && (idx == (v6_q ? 16'd5 : 16'd3));
    entry_o.proto_chk = counted && (v6_q ? (idx == 16'd6) : (idx == 16'd9));
    entry_o.proto_ok  = v6_q ? (data_byte_i == icmpchk_pkg::NextIcmpv6)
                             : (data_byte_i == icmpchk_pkg::ProtoIcmp);
    entry_o.seq_cap   = counted && (idx == hdr + 16'd7);
    entry_o.len       = len;
  end

  always_comb begin
    count_d = count_q;
    if (push_o) begin
      count_d = last_byte_i ? 16'd0 : len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 16'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/icmpchk_queue.sv
`timescale 1ns / 1ps

module icmpchk_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  icmpchk_pkg::entry_t   entry_i,
  input  logic                  pop_i,
  output icmpchk_pkg::entry_t   head_o,
  output icmpchk_pkg::q_stat_t  q_stat_o
);

  icmpchk_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign q_stat_o.full  = cnt_q == 2'd2;
  assign q_stat_o.empty = cnt_q == 2'd0;

endmodule

FILE: rtl/icmpchk_back.sv
`timescale 1ns / 1ps

module icmpchk_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  icmpchk_pkg::entry_t   head_i,
  input  icmpchk_pkg::q_stat_t  q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic signed [16:0]    echo_data_length_o
);

  logic [7:0]  pend_q, pend_d, pend_u;
  logic [15:0] sum_q, sum_d, sum_u;
  logic [15:0] hlf_q, hlf_d, hlf_u;
  logic        proto_q, proto_d, proto_u;
  logic [7:0]  seq_q, seq_d, seq_u;

  logic                  out_valid_q, out_valid_d;
  icmpchk_pkg::status_e  status_q, status_d, status_n;
  logic [16:0]           dlen_q, dlen_d, dlen_n;

  logic [15:0] operand;
  logic [16:0] raw_sum;
  logic [15:0] folded;
  logic        do_add, fin;
  logic [15:0] hdr;
  logic [16:0] pllen;

  // Non-final words never wait on the output side.
  assign pop_o = !q_stat_i.empty && (!head_i.last || !out_valid_q || !out_stall_i);
  assign fin   = pop_o && head_i.last;

  always_comb begin
    operand = 16'd0;
    if (head_i.add_word) begin
      operand = {pend_q, head_i.data};
    end else if (head_i.add_low) begin
      operand = {8'd0, head_i.data};
    end else if (head_i.pad) begin
      operand = {(head_i.hi_store ? head_i.data : pend_q), 8'd0};
    end
  end

  assign do_add  = head_i.add_word || head_i.add_low || head_i.pad;
  assign raw_sum = {1'b0, sum_q} + {1'b0, operand};
  // End-around carry
  assign folded  = raw_sum[16] ? raw_sum[15:0] + 16'd1 : raw_sum[15:0];

  always_comb begin
    pend_u  = pend_q;
    sum_u   = sum_q;
    hlf_u   = hlf_q;
    proto_u = proto_q;
    seq_u   = seq_q;
    if (pop_o) begin
      if (head_i.hi_store)  pend_u        = head_i.data;
      if (do_add)           sum_u         = folded;
      if (head_i.len_hi)    hlf_u[15:8]   = head_i.data;
      if (head_i.len_lo)    hlf_u[7:0]    = head_i.data;
      if (head_i.proto_chk) proto_u       = head_i.proto_ok;
      if (head_i.seq_cap)   seq_u         = head_i.data;
    end
  end

  assign hdr   = head_i.v6 ? icmpchk_pkg::V6Hdr : icmpchk_pkg::V4Hdr;
  assign pllen = {1'b0, hlf_u} + (head_i.v6 ? icmpchk_pkg::V6HdrWide : 17'd0);

  always_comb begin
    dlen_n = 17'd0;
    if (head_i.len < hdr) begin
      status_n = icmpchk_pkg::StShort;
    end else if (!proto_u) begin
      status_n = icmpchk_pkg::StNotIcmp;
    end else if (sum_u != icmpchk_pkg::SumGood) begin
      status_n = icmpchk_pkg::StChecksum;
    end else if (seq_u != head_i.exp_seq) begin
      status_n = icmpchk_pkg::StSequence;
    end else if (pllen != {1'b0, head_i.len}) begin
      status_n = icmpchk_pkg::StLength;
    end else begin
      status_n = icmpchk_pkg::StOk;
      dlen_n   = pllen - (head_i.v6 ? icmpchk_pkg::V6Strip : icmpchk_pkg::V4Strip);
    end
  end

  always_comb begin
    pend_d  = fin ? 8'd0  : pend_u;
    sum_d   = fin ? 16'd0 : sum_u;
    hlf_d   = fin ? 16'd0 : hlf_u;
    proto_d = fin ? 1'b0  : proto_u;
    seq_d   = fin ? 8'd0  : seq_u;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    dlen_d      = dlen_q;
    if (fin) begin
      out_valid_d = 1'b1;
      status_d    = status_n;
      dlen_d      = dlen_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 8'd0;
      sum_q       <= 16'd0;
      hlf_q       <= 16'd0;
      proto_q     <= 1'b0;
      seq_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      sum_q       <= sum_d;
      hlf_q       <= hlf_d;
      proto_q     <= proto_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    dlen_q   <= dlen_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign echo_data_length_o = dlen_q;

endmodule

FILE: rtl/icmp_echo_reply_checker_unit.sv
`timescale 1ns / 1ps

// Checks a received raw IPv4 or IPv6 packet that arrives one byte per word and,
// on the word carrying the final byte, returns one status (ok, too short, not
// ICMP, checksum, sequence, length) plus the echo data length. Sustained rate
// is one byte per clock unless the output stalls: each byte costs the back end
// at most one 16-bit add with end-around carry. Bytes pass through the two-word
// queue to the back end, and the result is registered as the final byte is
// popped. The input stalls only when the queue is full, which happens when a
// finished result sits unclaimed on the output and another final byte waits.
// Packets longer than 1280 bytes are counted as 1280 bytes; bytes past that
// are ignored. Config writes land immediately and affect bytes accepted after.
module icmp_echo_reply_checker_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [16:0] echo_data_length_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);

  logic                 push, pop;
  icmpchk_pkg::entry_t  entry, head;
  icmpchk_pkg::q_stat_t q_stat;

  icmpchk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .entry_o     (entry)
  );

  icmpchk_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .q_stat_o (q_stat)
  );

  icmpchk_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .q_stat_i           (q_stat),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .echo_data_length_o (echo_data_length_o)
  );

  a_len_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != icmpchk_pkg::StOk) |-> echo_data_length_o == 17'sd0)
    else $error("echo length nonzero on failing status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= icmpchk_pkg::StLength)
    else $error("status code out of range");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop && head.last))
    else $error("result without a final byte");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_push_clears_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 4000;
  localparam int ShowMax       = 10;
  localparam int TotalBytes    = 2300;

  typedef enum logic [1:0] {
    FeedByte,
    FeedCfg,
    FeedDrain
  } feed_kind_e;

  typedef enum logic [2:0] {
    FlawNone,
    FlawShort,
    FlawProto,
    FlawCsum,
    FlawSeq,
    FlawLen
  } flaw_e;

  typedef struct {
    feed_kind_e            kind;
    logic [7:0]            data;
    logic                  fin;
    icmpchk_pkg::cfg_idx_e idx;
    logic [7:0]            val;
  } feed_t;

  typedef struct {
    icmpchk_pkg::status_e status;
    logic signed [16:0]   dlen;
  } reply_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            status;
  logic signed [16:0]    echo_len;
  logic                  cfg_we = 1'b0;
  icmpchk_pkg::cfg_idx_e cfg_idx = icmpchk_pkg::CfgIpv6Mode;
  logic [7:0]            cfg_data = 8'h00;

  icmp_echo_reply_checker_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .data_byte_i        (data_byte),
    .last_byte_i        (last_byte),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status),
    .echo_data_length_o (echo_len),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  feed_t  feed_q[$];
  reply_t replies_due[$];

  // planned settings while building stimulus
  logic       plan_v6 = 1'b0;
  logic [7:0] plan_seq = 8'h00;
  int         bytes_queued = 0;

  // checker model state
  logic        v6_cfg = 1'b0;
  logic [7:0]  exp_seq_cfg = 8'h00;
  logic [15:0] byte_cnt = '0;
  logic [15:0] run_sum = '0;
  logic [7:0]  hi_byte = '0;
  logic [15:0] len_field = '0;
  logic        proto_seen = 1'b0;
  logic [7:0]  seq_seen = '0;

  int mismatches = 0;
  int replies_seen = 0;
  int cfg_writes = 0;
  int bytes_taken = 0;
  int st_hits[6];

  logic calm_in = 1'b0;
  logic calm_out = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   quiet = 0;
  int   idle_cycles = 0;
  int   cyc = 0;

  function automatic logic [15:0] ocsum_add(logic [15:0] acc, logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    if (s > 17'h0FFFF) s = s - 17'h0FFFF;
    return s[15:0];
  endfunction

  function automatic logic in_csum_span(logic [15:0] idx, logic v6);
    if (v6) return idx == 16'd4 || idx == 16'd5 || idx >= 16'd8;
    return idx >= icmpchk_pkg::V4Hdr;
  endfunction

  function automatic logic [15:0] packet_sum(input logic [7:0] pkt[$], input int n,
                                             input logic v6);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      if (in_csum_span(i[15:0], v6) && !i[0])
        acc = ocsum_add(acc, {pkt[i], (i + 1 < n) ? pkt[i+1] : 8'h00});
      else if (v6 && i == 6)
        acc = ocsum_add(acc, {8'h00, pkt[i]});
    end
    return acc;
  endfunction

  // One accepted word into the model; a final byte yields one reply.
  task automatic take_byte(input logic [7:0] b, input logic fin);
    logic [15:0]          hdr;
    logic [15:0]          n;
    logic [16:0]          plen;
    icmpchk_pkg::status_e st;
    logic signed [16:0]   dl;
    reply_t               r;
    hdr = v6_cfg ? icmpchk_pkg::V6Hdr : icmpchk_pkg::V4Hdr;
    if (byte_cnt < icmpchk_pkg::MaxPacketBytes) begin
      if (in_csum_span(byte_cnt, v6_cfg)) begin
        if (!byte_cnt[0]) hi_byte = b;
        else run_sum = ocsum_add(run_sum, {hi_byte, b});
      end else if (v6_cfg && byte_cnt == 16'd6) begin
        run_sum = ocsum_add(run_sum, {8'h00, b});
      end
      if (byte_cnt == (v6_cfg ? 16'd4 : 16'd2)) len_field[15:8] = b;
      else if (byte_cnt == (v6_cfg ? 16'd5 : 16'd3)) len_field[7:0] = b;
      if (v6_cfg && byte_cnt == 16'd6) proto_seen = (b == icmpchk_pkg::NextIcmpv6);
      else if (!v6_cfg && byte_cnt == 16'd9) proto_seen = (b == icmpchk_pkg::ProtoIcmp);
      if (byte_cnt == hdr + 16'd7) seq_seen = b;
      byte_cnt = byte_cnt + 16'd1;
    end
    if (fin) begin
      n = byte_cnt;
      if (n[0] && in_csum_span(n - 16'd1, v6_cfg))
        run_sum = ocsum_add(run_sum, {hi_byte, 8'h00});
      plen = {1'b0, len_field} + (v6_cfg ? icmpchk_pkg::V6HdrWide : 17'd0);
      dl = '0;
      if (n < hdr) st = icmpchk_pkg::StShort;
      else if (!proto_seen) st = icmpchk_pkg::StNotIcmp;
      else if (run_sum != icmpchk_pkg::SumGood) st = icmpchk_pkg::StChecksum;
      else if (seq_seen != exp_seq_cfg) st = icmpchk_pkg::StSequence;
      else if (plen != {1'b0, n}) st = icmpchk_pkg::StLength;
      else begin
        st = icmpchk_pkg::StOk;
        dl = plen - (v6_cfg ? icmpchk_pkg::V6Strip : icmpchk_pkg::V4Strip);
      end
      r.status = st;
      r.dlen = dl;
      replies_due.push_back(r);
      byte_cnt = '0;
      run_sum = '0;
      hi_byte = '0;
      len_field = '0;
      proto_seen = 1'b0;
      seq_seen = '0;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    feed_t f;
    f.kind = FeedByte;
    f.data = b;
    f.fin = fin;
    f.idx = icmpchk_pkg::CfgIpv6Mode;
    f.val = '0;
    feed_q.push_back(f);
    bytes_queued++;
  endtask

  task automatic push_cfg(input icmpchk_pkg::cfg_idx_e idx, input logic [7:0] v);
    feed_t f;
    f.kind = FeedCfg;
    f.data = '0;
    f.fin = 1'b0;
    f.idx = idx;
    f.val = v;
    feed_q.push_back(f);
    if (idx == icmpchk_pkg::CfgIpv6Mode) plan_v6 = v[0];
    else plan_seq = v;
  endtask

  task automatic push_drain();
    feed_t f;
    f.kind = FeedDrain;
    f.data = '0;
    f.fin = 1'b0;
    f.idx = icmpchk_pkg::CfgIpv6Mode;
    f.val = '0;
    feed_q.push_back(f);
  endtask

  // Echo reply of n bytes with a valid checksum over the first 1280 bytes; only
  // the checksum flaw is applied after it. A short packet is cut down to n bytes.
  task automatic make_packet(output logic [7:0] pkt[$], input logic v6,
                             input logic [7:0] seq, input int n, input flaw_e flaw);
    int          hdr;
    int          full;
    int          span;
    int          idx;
    logic [15:0] lf;
    logic [15:0] ck;
    logic [7:0]  rb;
    hdr = v6 ? 40 : 20;
    full = (n < hdr + 8) ? hdr + 8 + $urandom_range(0, 8) : n;
    span = (full < 1280) ? full : 1280;
    rb = 8'($urandom_range(1, 255));
    pkt = {};
    for (int i = 0; i < full; i++) pkt.push_back(8'($urandom_range(0, 255)));
    lf = 16'(v6 ? span - 40 : span);
    if (flaw == FlawLen) lf = lf + 16'($urandom_range(1, 300));
    if (v6) begin
      pkt[0] = 8'h60;
      pkt[4] = lf[15:8];
      pkt[5] = lf[7:0];
      pkt[6] = (flaw == FlawProto) ? icmpchk_pkg::NextIcmpv6 ^ rb
                                   : icmpchk_pkg::NextIcmpv6;
    end else begin
      pkt[0] = 8'h45;
      pkt[2] = lf[15:8];
      pkt[3] = lf[7:0];
      pkt[9] = (flaw == FlawProto) ? icmpchk_pkg::ProtoIcmp ^ rb
                                   : icmpchk_pkg::ProtoIcmp;
    end
    pkt[hdr] = 8'h00;
    pkt[hdr+1] = 8'h00;
    pkt[hdr+2] = 8'h00;
    pkt[hdr+3] = 8'h00;
    pkt[hdr+7] = (flaw == FlawSeq) ? seq ^ rb : seq;
    ck = ~packet_sum(pkt, span, v6);
    pkt[hdr+2] = ck[15:8];
    pkt[hdr+3] = ck[7:0];
    if (flaw == FlawCsum) begin
      idx = $urandom_range(hdr, span - 1);
      pkt[idx] = pkt[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  task automatic send_packet(input int n, input flaw_e flaw);
    logic [7:0] pkt[$];
    make_packet(pkt, plan_v6, plan_seq, n, flaw);
    for (int i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
  endtask

  function automatic int pick_gap(logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: words come from feed_q; config writes and drains wait for idle.
  always @(posedge clk_i or negedge rst_ni) begin
    logic                  nv;
    logic                  nl;
    logic                  nwe;
    logic                  settled;
    logic [7:0]            nd;
    logic [7:0]            ndat;
    icmpchk_pkg::cfg_idx_e nidx;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      data_byte <= 8'h00;
      last_byte <= 1'b0;
      cfg_we <= 1'b0;
      cfg_idx <= icmpchk_pkg::CfgIpv6Mode;
      cfg_data <= 8'h00;
      gap_left = 0;
      quiet = 0;
      v6_cfg = 1'b0;
      exp_seq_cfg = 8'h00;
    end else begin
      nv = in_valid;
      nd = data_byte;
      nl = last_byte;
      nwe = 1'b0;
      nidx = cfg_idx;
      ndat = cfg_data;
      if (cfg_we) begin
        cfg_writes++;
        if (cfg_idx == icmpchk_pkg::CfgIpv6Mode) v6_cfg = cfg_data[0];
        else exp_seq_cfg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        take_byte(data_byte, last_byte);
        bytes_taken++;
        nv = 1'b0;
      end
      if (in_valid || replies_due.size() != 0) quiet = 0;
      else if (quiet < SettleCycles) quiet++;
      settled = (quiet >= SettleCycles) && !in_valid;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (feed_q.size() != 0) begin
          case (feed_q[0].kind)
            FeedByte: begin
              nv = 1'b1;
              nd = feed_q[0].data;
              nl = feed_q[0].fin;
              void'(feed_q.pop_front());
              gap_left = pick_gap(calm_in);
            end
            FeedCfg: begin
              if (settled) begin
                nwe = 1'b1;
                nidx = feed_q[0].idx;
                ndat = feed_q[0].val;
                void'(feed_q.pop_front());
              end
            end
            default: begin
              if (settled) void'(feed_q.pop_front());
            end
          endcase
        end
      end
      in_valid <= nv;
      data_byte <= nd;
      last_byte <= nl;
      cfg_we <= nwe;
      cfg_idx <= nidx;
      cfg_data <= ndat;
    end
  end

  // Receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (calm_out || r < 70) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end
    end
  end

  // Reply checker
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid && !out_stall) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowMax)
          $display("unexpected reply: status %0d length %0d", status, echo_len);
      end else begin
        e = replies_due.pop_front();
        st_hits[e.status]++;
        if (status !== e.status || echo_len !== e.dlen) begin
          mismatches++;
          if (mismatches <= ShowMax)
            $display("reply %0d wrong: status exp %0d got %0d, length exp %0d got %0d",
                     replies_seen, e.status, status, e.dlen, echo_len);
        end
      end
    end
  end

  // Calm stretches and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calm_in <= 1'b0;
      calm_out <= 1'b0;
      cyc = 0;
      idle_cycles = 0;
    end else begin
      cyc++;
      if (cyc % 200 == 0) begin
        calm_in <= ($urandom_range(0, 3) == 0);
        calm_out <= ($urandom_range(0, 3) == 0);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles, %0d replies outstanding",
                 idle_cycles, replies_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] pkt[$];
    int         hdr;
    int         n;
    int         r;
    flaw_e      flaw;

    // directed: IPv4, sequence 0
    push_cfg(icmpchk_pkg::CfgIpv6Mode, 8'h00);
    push_cfg(icmpchk_pkg::CfgExpSeq, 8'h00);
    send_packet(28, FlawNone);           // bare echo header, no data
    send_packet(33, FlawNone);           // odd length, padded low byte
    send_packet(36, FlawProto);
    send_packet(36, FlawCsum);
    send_packet(36, FlawSeq);
    send_packet(36, FlawLen);
    push_byte(8'hFF, 1'b1);              // one-byte packet
    send_packet(19, FlawShort);
    send_packet(24, FlawShort);          // ends before the sequence byte
    for (int i = 0; i < 40; i++) push_byte(8'h00, i == 39);
    for (int i = 0; i < 40; i++) push_byte(8'hFF, i == 39);
    send_packet(1283, FlawNone);         // oversize, count saturates
    push_drain();

    // directed: IPv6, sequence 255
    push_cfg(icmpchk_pkg::CfgIpv6Mode, 8'h01);
    push_cfg(icmpchk_pkg::CfgExpSeq, 8'hFF);
    send_packet(48, FlawNone);
    send_packet(51, FlawNone);
    send_packet(50, FlawProto);
    send_packet(50, FlawCsum);
    send_packet(45, FlawShort);
    send_packet(30, FlawShort);

    // mode flips in the middle of a packet
    make_packet(pkt, 1'b1, 8'hFF, 60, FlawNone);
    for (int i = 0; i < 10; i++) push_byte(pkt[i], 1'b0);
    push_drain();
    push_cfg(icmpchk_pkg::CfgIpv6Mode, 8'h00);
    for (int i = 10; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
    push_cfg(icmpchk_pkg::CfgExpSeq, 8'h5A);

    // random: well-formed and flawed packets in equal share, some loose noise,
    // until the overall byte budget is used up
    while (bytes_queued < TotalBytes) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: push_drain();
          1: push_cfg(icmpchk_pkg::CfgIpv6Mode, 8'($urandom_range(0, 1)));
          default: begin
            r = $urandom_range(0, 3);
            push_cfg(icmpchk_pkg::CfgExpSeq,
                     (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
          end
        endcase
      end
      if ($urandom_range(0, 99) < 12) begin
        n = $urandom_range(1, 6);
        r = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
          push_byte(8'($urandom_range(0, 255)), (r != 0) && i == n - 1);
      end else begin
        hdr = plan_v6 ? 40 : 20;
        flaw = $urandom_range(0, 1) ? FlawNone : flaw_e'($urandom_range(1, 5));
        if (flaw == FlawShort) n = $urandom_range(1, hdr + 7);
        else n = hdr + 8 + $urandom_range(0, 24);
        send_packet(n, flaw);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (feed_q.size() != 0 || in_valid || cfg_we || replies_due.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d bytes in, %0d replies, %0d config writes, %0d mismatches",
             bytes_taken, replies_seen, cfg_writes, mismatches);
    $display("status mix ok/short/not-icmp/checksum/sequence/length: %0d/%0d/%0d/%0d/%0d/%0d",
             st_hits[0], st_hits[1], st_hits[2], st_hits[3], st_hits[4], st_hits[5]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/icmpchk_pkg.sv
rtl/icmpchk_front.sv
rtl/icmpchk_queue.sv
rtl/icmpchk_back.sv
rtl/icmp_echo_reply_checker_unit.sv
sim/tb_top.sv
